// ===== hw/rtl/tglc_pkg.sv =====
// package for the tile grid collision line checker
// shared constants, operation codes, tile codes and the validity function
`default_nettype none
package tglc_pkg;
    localparam int MAP_SIDE_DEF  = 64;
    localparam int FRAC_BITS_DEF = 8;
    localparam int COORD_W       = 16;
    localparam int DIM_W         = 7;
    localparam int CODE_W        = 3;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_BLOCK   = 3'd1;
    localparam logic [2:0] OP_UNBLOCK = 3'd2;
    localparam logic [2:0] OP_SIGHT   = 3'd3;
    localparam logic [2:0] OP_MOVE    = 3'd4;
    localparam logic [2:0] OP_CHECK   = 3'd5;

    localparam logic [2:0] TC_FREE   = 3'd0;
    localparam logic [2:0] TC_WALL   = 3'd1;
    localparam logic [2:0] TC_HWALL  = 3'd2;
    localparam logic [2:0] TC_MAP    = 3'd3;
    localparam logic [2:0] TC_MAPALT = 3'd4;
    localparam logic [2:0] TC_ENTITY = 3'd5;
    localparam logic [2:0] TC_ALLY   = 3'd6;

    localparam logic [1:0] MK_FLYING     = 2'd1;
    localparam logic [1:0] MK_INTANGIBLE = 2'd2;
    localparam logic [1:0] CK_ALL        = 2'd1;
    localparam logic [1:0] CK_HERO       = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;

    // tile validity for a movement and collide kind
    function automatic logic valid_code(input logic [2:0] code, input logic [1:0] mk,
                                        input logic [1:0] ck);
        logic r;
        begin
            if (ck == CK_ALL && (code == TC_ENTITY || code == TC_ALLY)) r = 1'b0;
            else if (ck == CK_HERO && code == TC_ALLY) r = 1'b1;
            else if (mk == MK_INTANGIBLE) r = 1'b1;
            else if (mk == MK_FLYING) r = !(code == TC_WALL || code == TC_HWALL);
            else r = (code == TC_FREE || code == TC_MAP || code == TC_MAPALT);
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/tile_grid_collision_line_check.sv =====
// tile grid collision map with sight and movement line walks
// tile updates and position checks read one tile, unused operations and moves needing no walk
// go straight to the result, line walks run the divider and then read each tile stepped
// one beat at a time: the next beat is taken the cycle after the result is loaded
// synchronous active-low reset, then a clearing pass writes every memory entry,
// one per cycle (4096 at the default size), before the first beat is taken
`default_nettype none
module tile_grid_collision_line_check import tglc_pkg::*; #(
    parameter int MAP_SIDE  = MAP_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_operation,
    input  wire logic [COORD_W-1:0] i_x_start,
    input  wire logic [COORD_W-1:0] i_y_start,
    input  wire logic [COORD_W-1:0] i_x_end,
    input  wire logic [COORD_W-1:0] i_y_end,
    input  wire logic [2:0]         i_tile_code,
    input  wire logic               i_is_ally,
    input  wire logic [1:0]         i_movement_kind,
    input  wire logic [1:0]         i_collide_kind,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_passed
);
    localparam int AW    = $clog2(MAP_SIDE);
    localparam int MW    = 2 * AW;
    localparam int DEPTH = 1 << MW;
    localparam int PW    = COORD_W + 2;  // signed point
    localparam int IW    = COORD_W - FRAC_BITS;
    localparam int SIDE_CAP = (MAP_SIDE > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1 : MAP_SIDE;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_EVAL = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state;
    logic [MW-1:0] r_clr;
    logic [DIM_W-1:0] r_w, r_h;
    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rd;

    logic [2:0] r_op;
    logic [2:0] r_code;
    logic r_ally;
    logic [1:0] r_mk, r_ck;
    logic signed [PW-1:0] r_px, r_py, r_sx, r_sy;
    logic r_xmaj, r_negx, r_negy;
    logic [IW-1:0] r_steps;
    logic [AW-1:0] r_tx, r_ty, r_gx, r_gy;
    logic r_inmap, r_pass, r_out, r_passed;

    // effective sizes
    logic [DIM_W:0] eff_w, eff_h;
    assign eff_w = {1'b0, (r_w > DIM_W'(SIDE_CAP)) ? DIM_W'(SIDE_CAP) : r_w};
    assign eff_h = {1'b0, (r_h > DIM_W'(SIDE_CAP)) ? DIM_W'(SIDE_CAP) : r_h};

    function automatic logic on_map(input logic signed [PW-1:0] px,
                                    input logic signed [PW-1:0] py,
                                    input logic [DIM_W:0] w, input logic [DIM_W:0] h);
        logic [PW-1:0] a, b;
        begin
            a = PW'($unsigned(px) >> FRAC_BITS);
            b = PW'($unsigned(py) >> FRAC_BITS);
            return !px[PW-1] && !py[PW-1] && (a < PW'(w)) && (b < PW'(h));
        end
    endfunction

    // input deltas
    logic [COORD_W-1:0] dx, dy, dmax;
    assign dx = (i_x_end > i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign dy = (i_y_end > i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;
    assign dmax = (dx > dy) ? dx : dy;
    logic in_start_map, in_end_map;
    assign in_start_map = on_map(PW'(i_x_start), PW'(i_y_start), eff_w, eff_h);
    assign in_end_map   = on_map(PW'(i_x_end), PW'(i_y_end), eff_w, eff_h);

    logic accept;
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    // the divider only runs for beats that walk a line
    logic div_start, div_done;
    logic [FRAC_BITS:0] div_q;
    assign div_start = accept && (i_operation == OP_SIGHT ||
                       (i_operation == OP_MOVE && in_end_map &&
                        i_movement_kind != MK_INTANGIBLE));
    tglc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num((dx > dy) ? dy : dx), .i_den((dx > dy) ? dx : dy),
        .o_done(div_done), .o_quot(div_q)
    );

    // next point
    logic signed [PW-1:0] nx, ny;
    assign nx = r_px + r_sx;
    assign ny = r_py + r_sy;
    logic [MW-1:0] rd_addr;
    assign rd_addr = {r_tx, r_ty};

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
            r_h <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) r_w <= i_cfg_data;
            else r_h <= i_cfg_data;
        end
    end

    // tile memory, one write and one read port
    logic mem_we;
    logic [MW-1:0] mem_wa;
    logic [CODE_W-1:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = rd_addr;
        mem_wd = r_code;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = TC_FREE;
        end else if (r_state == S_EVAL && r_inmap) begin
            if (r_op == OP_LOAD) mem_we = 1'b1;
            else if (r_op == OP_BLOCK && r_rd == TC_FREE) begin
                mem_we = 1'b1;
                mem_wd = r_ally ? TC_ALLY : TC_ENTITY;
            end else if (r_op == OP_UNBLOCK && (r_rd == TC_ENTITY || r_rd == TC_ALLY)) begin
                mem_we = 1'b1;
                mem_wd = TC_FREE;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[rd_addr];
    end

    // tile evaluation for a walk step
    logic [2:0] eff_code;
    logic step_ok;
    always_comb begin
        eff_code = r_rd;
        if (r_tx == r_gx && r_ty == r_gy && (r_rd == TC_ENTITY || r_rd == TC_ALLY))
            eff_code = TC_FREE;
        if (r_op == OP_SIGHT) step_ok = !(r_rd == TC_WALL || r_rd == TC_HWALL);
        else step_ok = valid_code(eff_code, r_mk, CK_ALL);
    end

    // result register, loaded when empty or being taken
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_out || !i_stall);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out    <= 1'b0;
            r_passed <= 1'b0;
        end else if (out_load) begin
            r_out    <= 1'b1;
            r_passed <= r_pass;
        end else if (r_out && !i_stall) begin
            r_out    <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MW'(DEPTH-1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op   <= i_operation;
                        r_code <= i_tile_code;
                        r_ally <= i_is_ally;
                        r_mk   <= i_movement_kind;
                        r_ck   <= i_collide_kind;
                        r_px   <= PW'(i_x_start);
                        r_py   <= PW'(i_y_start);
                        r_negx <= i_x_start > i_x_end;
                        r_negy <= i_y_start > i_y_end;
                        r_xmaj <= dx > dy;
                        r_steps <= dmax[COORD_W-1:FRAC_BITS];
                        r_tx   <= AW'(i_x_start >> FRAC_BITS);
                        r_ty   <= AW'(i_y_start >> FRAC_BITS);
                        r_gx   <= AW'(i_x_end >> FRAC_BITS);
                        r_gy   <= AW'(i_y_end >> FRAC_BITS);
                        case (i_operation)
                            OP_LOAD: begin
                                r_inmap <= (i_x_start >> FRAC_BITS) < COORD_W'(MAP_SIDE)
                                        && (i_y_start >> FRAC_BITS) < COORD_W'(MAP_SIDE);
                                r_pass  <= 1'b1;
                                r_state <= S_RD;
                            end
                            OP_BLOCK, OP_UNBLOCK: begin
                                r_inmap <= in_start_map;
                                r_pass  <= 1'b1;
                                r_state <= S_RD;
                            end
                            OP_CHECK: begin
                                r_inmap <= in_start_map;
                                r_pass  <= 1'b0;
                                r_state <= S_RD;
                            end
                            OP_SIGHT: begin
                                r_pass  <= 1'b1;
                                r_state <= S_DIV;
                            end
                            OP_MOVE: begin
                                r_pass  <= in_end_map;
                                r_state <= (in_end_map && i_movement_kind != MK_INTANGIBLE)
                                         ? S_DIV : S_OUT;
                            end
                            default: begin
                                r_pass  <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_xmaj) begin
                            r_sx <= r_negx ? -PW'(1 << FRAC_BITS) : PW'(1 << FRAC_BITS);
                            r_sy <= r_negy ? -PW'(div_q) : PW'(div_q);
                        end else begin
                            r_sy <= r_negy ? -PW'(1 << FRAC_BITS) : PW'(1 << FRAC_BITS);
                            r_sx <= r_negx ? -PW'(div_q) : PW'(div_q);
                        end
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_steps == '0) begin
                        r_state <= S_OUT;
                    end else if (!on_map(nx, ny, eff_w, eff_h)) begin
                        r_pass  <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_px    <= nx;
                        r_py    <= ny;
                        r_tx    <= AW'($unsigned(nx) >> FRAC_BITS);
                        r_ty    <= AW'($unsigned(ny) >> FRAC_BITS);
                        r_steps <= r_steps - 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    if (r_op == OP_SIGHT || r_op == OP_MOVE) begin
                        if (!step_ok) begin
                            r_pass  <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end else begin
                        if (r_op == OP_CHECK)
                            r_pass <= r_inmap && valid_code(r_rd, r_mk, r_ck);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out;
    assign o_passed = r_passed;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept) else $error("beat taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_passed)))
        else $error("result dropped under stall");
    a_div_only_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV)) else $error("divider finished out of turn");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/tglc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tglc_pkg for the coordinate width and the default fraction width
`default_nettype none
module tglc_div import tglc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [COORD_W-1:0]   i_num,
    input  wire logic [COORD_W-1:0]   i_den,
    output logic                      o_done,
    output logic [FRAC_BITS:0]        o_quot
);
    // quotient is at most 1.0 since num <= den
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic [COORD_W:0]   r_rem;
    logic [COORD_W-1:0] r_den;
    logic [QW-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [COORD_W+1:0] n_trial;

    assign n_trial = {r_rem, 1'b0} - {2'b00, r_den};

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            if (r_cnt == CW'(QW)) begin
                // first bit: integer part, num >= den
                if ({1'b0, r_rem} >= {2'b00, r_den}) begin
                    r_rem <= r_rem - {1'b0, r_den};
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end else if (!n_trial[COORD_W+1]) begin
                r_rem <= n_trial[COORD_W:0];
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[COORD_W-1:0], 1'b0};
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_quot = (r_cnt == CW'(1)) ? {r_q[QW-2:0], ~n_trial[COORD_W+1]} : r_q;
endmodule
`default_nettype wire

// ===== dv/tile_grid_collision_line_check_monitor.sv =====
// monitor for the tile grid collision line checker: watches both channels and
// the register port, predicts passed from its own tile store copy and compares
// depends on tglc_pkg
`default_nettype none
module tile_grid_collision_line_check_monitor import tglc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    input  wire logic               i_in_stall,
    input  wire logic [2:0]         i_operation,
    input  wire logic [COORD_W-1:0] i_x_start,
    input  wire logic [COORD_W-1:0] i_y_start,
    input  wire logic [COORD_W-1:0] i_x_end,
    input  wire logic [COORD_W-1:0] i_y_end,
    input  wire logic [2:0]         i_tile_code,
    input  wire logic               i_is_ally,
    input  wire logic [1:0]         i_movement_kind,
    input  wire logic [1:0]         i_collide_kind,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_passed,
    output int                      o_fail_count,
    output int                      o_pending
);
    localparam int SIDE = MAP_SIDE_DEF;
    localparam int FB   = FRAC_BITS_DEF;

    logic [CODE_W-1:0] tiles [0:SIDE*SIDE-1];
    logic [DIM_W-1:0]  cols_in_use;
    logic [DIM_W-1:0]  rows_in_use;
    bit                passed_due [$];
    int                fail_count;
    int                beat_no;

    assign o_fail_count = fail_count;
    assign o_pending    = passed_due.size();

    initial fail_count = 0;

    // tile under a signed point, or off the map in use
    function automatic bit on_map(input int px, input int py, output int tx, output int ty);
        int w;
        int h;
        begin
            w = (cols_in_use > SIDE) ? SIDE : int'(cols_in_use);
            h = (rows_in_use > SIDE) ? SIDE : int'(rows_in_use);
            tx = px >>> FB;
            ty = py >>> FB;
            return !(px < 0 || py < 0 || tx >= w || ty >= h);
        end
    endfunction

    function automatic bit tile_ok(input logic [2:0] code, input logic [1:0] mk,
                                   input logic [1:0] ck);
        begin
            if (ck == CK_ALL && (code == TC_ENTITY || code == TC_ALLY)) return 1'b0;
            if (ck == CK_HERO && code == TC_ALLY) return 1'b1;
            if (mk == MK_INTANGIBLE) return 1'b1;
            if (mk == MK_FLYING) return code != TC_WALL && code != TC_HWALL;
            return code == TC_FREE || code == TC_MAP || code == TC_MAPALT;
        end
    endfunction

    // step along the line; sight stops on walls, movement on invalid tiles
    function automatic bit line_clear(input int unsigned x1, input int unsigned y1,
                                      input int unsigned x2, input int unsigned y2,
                                      input bit sight, input logic [1:0] mk,
                                      input int gx, input int gy);
        int unsigned dx;
        int unsigned dy;
        int unsigned steps;
        int          sx;
        int          sy;
        int          px;
        int          py;
        int          tx;
        int          ty;
        logic [2:0]  code;
        begin
            dx = (x2 > x1) ? x2 - x1 : x1 - x2;
            dy = (y2 > y1) ? y2 - y1 : y1 - y2;
            steps = ((dx > dy) ? dx : dy) >> FB;
            if (dx > dy) begin
                sx = 1 << FB;
                sy = int'((dy << FB) / dx);
            end else begin
                sy = 1 << FB;
                sx = (dy != 0) ? int'((dx << FB) / dy) : 0;
            end
            if (x1 > x2) sx = -sx;
            if (y1 > y2) sy = -sy;
            px = int'(x1);
            py = int'(y1);
            for (int unsigned i = 0; i < steps; i++) begin
                px += sx;
                py += sy;
                if (!on_map(px, py, tx, ty)) return 1'b0;
                code = tiles[tx*SIDE + ty];
                if (sight) begin
                    if (code == TC_WALL || code == TC_HWALL) return 1'b0;
                end else begin
                    if (tx == gx && ty == gy && (code == TC_ENTITY || code == TC_ALLY))
                        code = TC_FREE;
                    if (!tile_ok(code, mk, CK_ALL)) return 1'b0;
                end
            end
            return 1'b1;
        end
    endfunction

    // track registers and tile updates, queue the expected passed bit
    always @(posedge i_clk) begin
        int   tx;
        int   ty;
        int   a;
        int   b;
        bit   res;
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE*SIDE; k++) tiles[k] = TC_FREE;
            cols_in_use = '0;
            rows_in_use = '0;
            passed_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_WIDTH) cols_in_use = i_cfg_data;
                else rows_in_use = i_cfg_data;
            end
            if (i_valid && !i_in_stall) begin
                res = 1'b0;
                case (i_operation)
                    OP_LOAD: begin
                        a = i_x_start >> FB;
                        b = i_y_start >> FB;
                        if (a < SIDE && b < SIDE) tiles[a*SIDE + b] = i_tile_code;
                        res = 1'b1;
                    end
                    OP_BLOCK: begin
                        if (on_map(i_x_start, i_y_start, tx, ty) &&
                            tiles[tx*SIDE + ty] == TC_FREE)
                            tiles[tx*SIDE + ty] = i_is_ally ? TC_ALLY : TC_ENTITY;
                        res = 1'b1;
                    end
                    OP_UNBLOCK: begin
                        if (on_map(i_x_start, i_y_start, tx, ty) &&
                            (tiles[tx*SIDE + ty] == TC_ENTITY || tiles[tx*SIDE + ty] == TC_ALLY))
                            tiles[tx*SIDE + ty] = TC_FREE;
                        res = 1'b1;
                    end
                    OP_SIGHT:
                        res = line_clear(i_x_start, i_y_start, i_x_end, i_y_end,
                                         1'b1, 2'd0, 0, 0);
                    OP_MOVE: begin
                        if (!on_map(i_x_end, i_y_end, tx, ty)) res = 1'b0;
                        else if (i_movement_kind == MK_INTANGIBLE) res = 1'b1;
                        else res = line_clear(i_x_start, i_y_start, i_x_end, i_y_end,
                                              1'b0, i_movement_kind, tx, ty);
                    end
                    OP_CHECK: begin
                        if (on_map(i_x_start, i_y_start, tx, ty))
                            res = tile_ok(tiles[tx*SIDE + ty], i_movement_kind,
                                          i_collide_kind);
                    end
                    default: res = 1'b0;
                endcase
                passed_due = {passed_due, res};
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            beat_no++;
            if (passed_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result beat %0d: passed=%0b with nothing expected",
                             beat_no, i_passed);
            end else begin
                want = passed_due.pop_front();
                if (i_passed !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result beat %0d: passed expected %0b actual %0b",
                                 beat_no, want, i_passed);
                end
            end
        end
    end

    initial beat_no = 0;
endmodule
`default_nettype wire

// ===== dv/tile_grid_collision_line_check_tb.sv =====
// testbench top for the tile grid collision line checker: clock, reset,
// register writes, directed and random operation beats, and the verdict
// depends on tglc_pkg, the block and tile_grid_collision_line_check_monitor
`default_nettype none
module tile_grid_collision_line_check_tb;
    import tglc_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [2:0] TC_OTHER   = 3'd7;
    localparam logic [1:0] MK_NORMAL  = 2'd0;
    localparam logic [1:0] MK_SPARE   = 2'd3;
    localparam logic [1:0] CK_NORMAL  = 2'd0;
    localparam logic [1:0] CK_SPARE   = 2'd3;
    localparam logic [15:0] ZERO      = 16'h0000;
    localparam int         STALL_LIMIT   = 30000;
    localparam int         BEATS_A_PHASE = 190;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_index = '0;
    logic [DIM_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_operation = '0;
    logic [COORD_W-1:0] i_x_start = '0;
    logic [COORD_W-1:0] i_y_start = '0;
    logic [COORD_W-1:0] i_x_end = '0;
    logic [COORD_W-1:0] i_y_end = '0;
    logic [2:0]         i_tile_code = '0;
    logic               i_is_ally = 1'b0;
    logic [1:0]         i_movement_kind = '0;
    logic [1:0]         i_collide_kind = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_passed;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int cols = 0;
    int rows = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tile_grid_collision_line_check uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_stall, .i_operation, .i_x_start, .i_y_start, .i_x_end, .i_y_end,
        .i_tile_code, .i_is_ally, .i_movement_kind, .i_collide_kind,
        .o_valid, .i_stall, .o_passed
    );

    tile_grid_collision_line_check_monitor mon (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall), .i_operation, .i_x_start, .i_y_start,
        .i_x_end, .i_y_end, .i_tile_code, .i_is_ally, .i_movement_kind,
        .i_collide_kind, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_passed(o_passed), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver back-pressure
    always @(posedge i_clk) i_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tile_grid_collision_line_check verification failed");
            $finish;
        end
    end

    // one operation beat, with an optional random gap first
    task automatic put(input logic [2:0] op, input logic [15:0] xs, input logic [15:0] ys,
                       input logic [15:0] xe, input logic [15:0] ye, input logic [2:0] code,
                       input logic ally, input logic [1:0] mk, input logic [1:0] ck);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_operation <= op;
        i_x_start <= xs;
        i_y_start <= ys;
        i_x_end <= xe;
        i_y_end <= ye;
        i_tile_code <= code;
        i_is_ally <= ally;
        i_movement_kind <= mk;
        i_collide_kind <= ck;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // register write once the block has drained
    task automatic set_map(input int w, input int h);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data <= w[DIM_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data <= h[DIM_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cols = (w > 64) ? 64 : w;
        rows = (h > 64) ? 64 : h;
    endtask

    // mostly near the map in use, sometimes anywhere in the coordinate range
    function automatic logic [15:0] pick_coord(input int lim);
        if ($urandom_range(0, 99) < 12) return 16'($urandom);
        return 16'($urandom_range(0, ((lim + 2) << 8) - 1));
    endfunction

    function automatic logic [15:0] at(input int t);
        return 16'((t << 8) | 8'h80);
    endfunction

    initial begin
        int          map_dims [6][2] = '{'{64, 64}, '{0, 0}, '{127, 127}, '{1, 64},
                                         '{37, 21}, '{64, 1}};
        int          r;
        logic [2:0]  op;
        logic [15:0] xs;
        logic [15:0] ys;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats on a full map
        set_map(64, 64);
        put(OP_LOAD, 16'h0000, 16'h0000, ZERO, ZERO, TC_WALL, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_LOAD, 16'h3FFF, 16'h3FFF, ZERO, ZERO, TC_OTHER, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_LOAD, 16'hFFFF, 16'hFFFF, ZERO, ZERO, TC_WALL, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_LOAD, 16'h4000, 16'h0000, ZERO, ZERO, TC_WALL, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_LOAD, at(10), at(10), ZERO, ZERO, TC_MAP, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_LOAD, at(11), at(10), ZERO, ZERO, TC_HWALL, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_BLOCK, at(5), at(5), ZERO, ZERO, TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_BLOCK, at(5), at(5), ZERO, ZERO, TC_FREE, 1'b1, MK_NORMAL, CK_NORMAL);
        put(OP_BLOCK, at(6), at(5), ZERO, ZERO, TC_FREE, 1'b1, MK_NORMAL, CK_NORMAL);
        put(OP_BLOCK, at(70), at(2), ZERO, ZERO, TC_FREE, 1'b1, MK_NORMAL, CK_NORMAL);
        put(OP_UNBLOCK, at(0), at(0), ZERO, ZERO, TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_CHECK, at(6), at(5), ZERO, ZERO, TC_FREE, 1'b0, MK_NORMAL, CK_HERO);
        put(OP_CHECK, at(5), at(5), ZERO, ZERO, TC_FREE, 1'b0, MK_INTANGIBLE, CK_ALL);
        put(OP_CHECK, at(0), at(0), ZERO, ZERO, TC_FREE, 1'b0, MK_INTANGIBLE, CK_SPARE);
        put(OP_CHECK, at(10), at(10), ZERO, ZERO, TC_FREE, 1'b0, MK_SPARE, CK_NORMAL);
        put(OP_UNBLOCK, at(6), at(5), ZERO, ZERO, TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_SIGHT, at(1), at(0), at(1), at(10), TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_SIGHT, at(3), at(0), 16'h0080, at(0), TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_SIGHT, at(60), at(60), 16'hFFFF, 16'hFFFF, TC_FREE, 1'b0, MK_NORMAL,
            CK_NORMAL);
        put(OP_SIGHT, at(2), at(2), at(2), at(2), TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_MOVE, at(4), at(5), at(5), at(5), TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_MOVE, at(4), at(5), at(7), at(5), TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);
        put(OP_MOVE, at(4), at(5), 16'hFFFF, at(5), TC_FREE, 1'b0, MK_INTANGIBLE, CK_NORMAL);
        put(OP_MOVE, at(0), at(0), at(50), at(3), TC_FREE, 1'b0, MK_INTANGIBLE, CK_NORMAL);
        put(OP_MOVE, at(8), at(10), at(12), at(10), TC_FREE, 1'b0, MK_FLYING, CK_NORMAL);
        put(OP_MOVE, at(8), at(10), at(10), at(10), TC_FREE, 1'b0, MK_SPARE, CK_NORMAL);
        put(OP_SPARE_A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, TC_OTHER, 1'b1, MK_SPARE,
            CK_SPARE);
        put(OP_SPARE_B, ZERO, ZERO, ZERO, ZERO, TC_FREE, 1'b0, MK_NORMAL, CK_NORMAL);

        // random phases over map sizes and idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            set_map(map_dims[ph][0], map_dims[ph][1]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < BEATS_A_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 28) op = OP_LOAD;
                else if (r < 38) op = OP_BLOCK;
                else if (r < 45) op = OP_UNBLOCK;
                else if (r < 65) op = OP_SIGHT;
                else if (r < 87) op = OP_MOVE;
                else if (r < 97) op = OP_CHECK;
                else op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                xs = pick_coord(cols);
                ys = pick_coord(rows);
                put(op, xs, ys, pick_coord(cols), pick_coord(rows),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
            send_idle_pct = 0;
        end
        i_valid <= 1'b0;

        // drain, then a short settle
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("tile_grid_collision_line_check verification clean");
        else
            $display("tile_grid_collision_line_check verification failed");
        $finish;
    end
endmodule
`default_nettype wire
